@@ hw/rtl/sstf_pkg.sv @@
// Shared types and constants for the shortest-seek-time-first disk scheduler.
// Holds the sequencer state type and the fixed field widths of the stream words.
// Depends on nothing.
package sstf_pkg;

	// Field widths of the request and result words
	localparam int CYL_W     = 16;
	localparam int MOVE_W    = 22;
	localparam int SUM_W     = 23;

	// Packed stream data widths, padded to whole bytes
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 40;
	localparam int OUT_PAD_W = M_TDATA_W - CYL_W - MOVE_W;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} sstf_state_t;

endpackage

@@ hw/rtl/sstf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the request store of the disk scheduler; depends on nothing.
module sstf_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/sstf_disk_scheduler.sv @@
// Shortest-seek-time-first disk scheduler, top level.
// Depends on sstf_pkg (types, widths) and sstf_ram (request store).
//
// Usage: stream cylinder requests in, one per word, and mark the final
// request of a batch with tlast. Up to MAX_REQUESTS requests are kept;
// further ones are dropped, but a tlast on a dropped word still closes the
// batch. The head then starts at the configured start position and the
// block serves the batch: each pick takes the unserved request nearest the
// head (an equal distance goes to the earliest-loaded request) and sends
// out one result word carrying the served cylinder and the head movement
// summed so far. The result word of the final pick has tlast set and holds
// the batch total. Loading accepts one request word per cycle. Each pick
// scans every stored request through the single read port of the request
// store with one shared distance-and-compare unit; a result that the sink
// does not take stalls the next pick. The input side is not ready while a
// batch is being served. Write the start position on the configuration
// channel only while the block is idle; it is sampled when the batch
// closes.
module sstf_disk_scheduler #(
	parameter int MAX_REQUESTS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,

	// Configuration: start position of the head
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sstf_pkg::CYL_W-1:0]     cfg_data,

	// Request words
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [sstf_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [15:0] cylinder
	input  logic                           s_axis_tlast,  // last request of the batch

	// Result words
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [sstf_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [15:0] served_cylinder,
	                                                      // [37:16] total_movement,
	                                                      // [39:38] zero
	output logic                           m_axis_tlast   // done_res: final result
);

	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam int CYL_W = sstf_pkg::CYL_W;
	localparam int SUM_W = sstf_pkg::SUM_W;

	// Sequencer state and counters
	sstf_pkg::sstf_state_t state_q, state_nxt;
	logic [CNT_W-1:0]      cnt_q;      // requests stored in the batch
	logic [CNT_W-1:0]      k_q;        // results already sent
	logic [IDX_W-1:0]      addr_q;     // scan read address

	// Scan compare stage
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [CYL_W-1:0]      rd_cyl;

	// Best candidate of the current pick
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [CYL_W-1:0]      best_d_q;
	logic [CYL_W-1:0]      best_cyl_q;

	// Head, movement sum, served marks, start position
	logic [CYL_W-1:0]      head_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SUM_W-1:0]      sum_nxt;
	logic [MAX_REQUESTS-1:0] served_q;
	logic [CYL_W-1:0]      start_q;

	// Output register
	logic                  out_vld_q;
	logic [CYL_W-1:0]      out_cyl_q;
	logic [sstf_pkg::MOVE_W-1:0] out_move_q;
	logic                  out_last_q;

	// Control strobes
	logic                  in_acc;
	logic                  store_ok;
	logic                  batch_start;
	logic                  last_addr;
	logic                  slot_free;
	logic                  emit;
	logic                  emit_last;
	logic [CNT_W-1:0]      k_inc;
	logic [CYL_W-1:0]      seek_d;
	logic                  better;

	// ------------------------------------------------------------------
	// Configuration: always ready, one register
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid) begin
			start_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Request store
	// ------------------------------------------------------------------
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign store_ok = cnt_q < CNT_W'(MAX_REQUESTS);

	sstf_ram #(
		.WIDTH (CYL_W),
		.DEPTH (MAX_REQUESTS),
		.ADDR_W(IDX_W)
	) u_store (
		.clk    (clk),
		.wr_en  (in_acc && store_ok),
		.wr_addr(cnt_q[IDX_W-1:0]),
		.wr_data(s_axis_tdata[CYL_W-1:0]),
		.rd_en  (state_q == sstf_pkg::ST_SCAN),
		.rd_addr(addr_q),
		.rd_data(rd_cyl)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	assign last_addr = (CNT_W'(addr_q) + CNT_W'(1)) == cnt_q;
	assign slot_free = !out_vld_q || m_axis_tready;
	assign k_inc     = k_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sstf_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		s_axis_tready = 1'b0;
		batch_start   = 1'b0;
		emit          = 1'b0;
		emit_last     = 1'b0;
		unique case (state_q)
			sstf_pkg::ST_LOAD: begin
				s_axis_tready = 1'b1;
				if (in_acc && s_axis_tlast) begin
					batch_start = 1'b1;
					state_nxt   = sstf_pkg::ST_SCAN;
				end
			end
			sstf_pkg::ST_SCAN: begin
				if (last_addr) begin
					state_nxt = sstf_pkg::ST_DRAIN;
				end
			end
			sstf_pkg::ST_DRAIN: begin
				// last read word is compared in this cycle
				state_nxt = sstf_pkg::ST_EMIT;
			end
			sstf_pkg::ST_EMIT: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_last = k_inc == cnt_q;
					state_nxt = emit_last ? sstf_pkg::ST_LOAD : sstf_pkg::ST_SCAN;
				end
			end
			default: begin
				state_nxt = sstf_pkg::ST_LOAD;
			end
		endcase
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			k_q    <= '0;
			addr_q <= '0;
		end else begin
			if (in_acc && store_ok) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (emit_last) begin
				cnt_q <= '0;
			end
			if (batch_start) begin
				k_q <= '0;
			end else if (emit) begin
				k_q <= k_inc;
			end
			if (state_q == sstf_pkg::ST_SCAN) begin
				addr_q <= addr_q + IDX_W'(1);
			end else begin
				addr_q <= '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Shared distance and compare unit
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= state_q == sstf_pkg::ST_SCAN;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
	end

	assign seek_d = (head_q >= rd_cyl) ? (head_q - rd_cyl) : (rd_cyl - head_q);
	// strict compare keeps the earliest-loaded request on a tie
	assign better = rd_vld_s1 && !served_q[idx_s1] && (!found_q || seek_d < best_d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (batch_start || emit) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			best_idx_q <= idx_s1;
			best_d_q   <= seek_d;
			best_cyl_q <= rd_cyl;
		end
	end

	// ------------------------------------------------------------------
	// Head, movement and served marks
	// ------------------------------------------------------------------
	assign sum_nxt = sum_q + SUM_W'(best_d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			sum_q    <= '0;
			served_q <= '0;
		end else if (batch_start) begin
			head_q   <= start_q;
			sum_q    <= '0;
			served_q <= '0;
		end else if (emit) begin
			head_q               <= best_cyl_q;
			sum_q                <= sum_nxt;
			served_q[best_idx_q] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Output register: hold the word until the sink takes it
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_cyl_q  <= best_cyl_q;
			out_move_q <= sum_nxt[sstf_pkg::MOVE_W-1:0];
			out_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{sstf_pkg::OUT_PAD_W{1'b0}}, out_move_q, out_cyl_q};
	assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
	// Hold a waiting result word until the sink takes it
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("result word changed while waiting");

	// One served mark per result sent during serving
	a_marks_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sstf_pkg::ST_LOAD) |-> ($countones(served_q) == int'(k_q)))
		else $error("served marks out of step with result count");

	// A pick always has a candidate when it is sent
	a_found_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sstf_pkg::ST_EMIT) |-> found_q)
		else $error("pick without candidate");

	// Stored request count stays within capacity
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_REQUESTS))
		else $error("request count beyond capacity");
`endif

endmodule
